// File: rtl/core/spm_pkg.sv
// shared types and constants of the sparse polynomial multiplier
package spm_pkg;

  localparam int SUM_W  = 38;  // accumulated coefficient width
  localparam int PWR_W  = 9;   // result exponent width
  localparam int KIND_W = 2;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MUL    = 2'd2;

  // one product travelling down the chain, or one table entry held in a cell
  typedef struct packed {
    logic             vld;
    logic [PWR_W-1:0] pwr;
    logic [SUM_W-1:0] coef;
  } term_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic clr;
  } gen_cmd_t;

  typedef struct packed {
    logic empty;
    logic busy;
    logic ovf;
  } gen_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT,
    ST_NONE
  } state_t;

endpackage

// File: rtl/core/spm_cell.sv
// one accumulator cell: holds a table entry and passes unmatched products on
module spm_cell (
  input  logic              clk,
  input  logic              rst,
  input  spm_pkg::cell_ctl_t ctl,
  input  spm_pkg::term_t    pkt_in,
  input  spm_pkg::term_t    nbr,
  output spm_pkg::term_t    pkt_out,
  output spm_pkg::term_t    ent
);

  logic hit;
  logic claim;

  assign hit   = pkt_in.vld && ent.vld && (ent.pwr == pkt_in.pwr);
  assign claim = pkt_in.vld && !ent.vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.vld     <= 1'b0;
      pkt_out.vld <= 1'b0;
    end else if (ctl.clr) begin
      ent.vld     <= 1'b0;
      pkt_out.vld <= 1'b0;
    end else if (ctl.shift) begin
      // emit: the table moves one cell toward the output
      ent         <= nbr;
      pkt_out.vld <= 1'b0;
    end else begin
      pkt_out.pwr  <= pkt_in.pwr;
      pkt_out.coef <= pkt_in.coef;
      pkt_out.vld  <= pkt_in.vld && !hit && !claim;
      if (hit) begin
        ent.coef <= ent.coef + pkt_in.coef;
      end else if (claim) begin
        ent <= pkt_in;
      end
    end
  end

endmodule

// File: rtl/core/spm_prod_gen.sv
// term stores, pair sequencer and multiplier feeding the cell chain
module spm_prod_gen #(
  parameter int MAX_TERMS  = 8,
  parameter int COEFF_BITS = 16,
  parameter int POWER_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  spm_pkg::gen_cmd_t  cmd,
  input  logic signed [15:0] coeff,
  input  logic [7:0]         power,
  output spm_pkg::term_t     pkt,
  output spm_pkg::gen_sts_t  sts
);

  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int EXT_C = (COEFF_BITS > 16) ? COEFF_BITS : 16;
  localparam int EXT_P = (POWER_BITS > 8) ? POWER_BITS : 8;
  localparam int EXT_S = (POWER_BITS + 1 > spm_pkg::PWR_W) ? POWER_BITS + 1 : spm_pkg::PWR_W;
  localparam int MUL_W = 2 * COEFF_BITS;
  localparam int EXT_M = spm_pkg::SUM_W + MUL_W;

  logic signed [COEFF_BITS-1:0] coa [MAX_TERMS];
  logic signed [COEFF_BITS-1:0] cob [MAX_TERMS];
  logic [POWER_BITS-1:0]        poa [MAX_TERMS];
  logic [POWER_BITS-1:0]        pob [MAX_TERMS];

  logic [CNT_W-1:0] cnt_a;
  logic [CNT_W-1:0] cnt_b;
  logic             ovf;
  logic             run;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;

  logic signed [COEFF_BITS-1:0] ca;
  logic signed [COEFF_BITS-1:0] cb;
  logic [spm_pkg::PWR_W-1:0]    psum;
  logic                         va;

  logic signed [EXT_C-1:0] cx;
  logic [EXT_P-1:0]        px;
  logic [EXT_S-1:0]        sx;
  logic signed [MUL_W-1:0] mul;
  logic signed [EXT_M-1:0] mul_ext;
  logic full_a;
  logic full_b;
  logic i_last;
  logic j_last;

  assign cx      = EXT_C'(coeff);
  assign px      = EXT_P'(power);
  assign sx      = EXT_S'(poa[i]) + EXT_S'(pob[j]);
  assign mul     = ca * cb;
  assign mul_ext = EXT_M'(mul);
  assign full_a  = (cnt_a == CNT_W'(MAX_TERMS));
  assign full_b  = (cnt_b == CNT_W'(MAX_TERMS));
  assign i_last  = (CNT_W'(i) + CNT_W'(1) == cnt_a);
  assign j_last  = (CNT_W'(j) + CNT_W'(1) == cnt_b);

  assign sts.empty = (cnt_a == '0) || (cnt_b == '0);
  assign sts.busy  = run || va || pkt.vld;
  assign sts.ovf   = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a   <= '0;
      cnt_b   <= '0;
      ovf     <= 1'b0;
      run     <= 1'b0;
      va      <= 1'b0;
      pkt.vld <= 1'b0;
    end else begin
      if (cmd.clr) begin
        cnt_a <= '0;
        cnt_b <= '0;
        ovf   <= 1'b0;
      end else begin
        if (cmd.load_a) begin
          if (full_a) ovf <= 1'b1;
          else cnt_a <= cnt_a + CNT_W'(1);
        end
        if (cmd.load_b) begin
          if (full_b) ovf <= 1'b1;
          else cnt_b <= cnt_b + CNT_W'(1);
        end
      end
      // first-term index outer, second-term index inner
      if (cmd.start) begin
        run <= 1'b1;
        i   <= '0;
        j   <= '0;
      end else if (run) begin
        if (j_last) begin
          j <= '0;
          if (i_last) run <= 1'b0;
          else i <= i + IDX_W'(1);
        end else begin
          j <= j + IDX_W'(1);
        end
      end
      va       <= run;
      pkt.vld  <= va;
      pkt.coef <= mul_ext[spm_pkg::SUM_W-1:0];
      pkt.pwr  <= psum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_a && !full_a) begin
      coa[cnt_a[IDX_W-1:0]] <= cx[COEFF_BITS-1:0];
      poa[cnt_a[IDX_W-1:0]] <= px[POWER_BITS-1:0];
    end
    if (cmd.load_b && !full_b) begin
      cob[cnt_b[IDX_W-1:0]] <= cx[COEFF_BITS-1:0];
      pob[cnt_b[IDX_W-1:0]] <= px[POWER_BITS-1:0];
    end
    ca   <= coa[i];
    cb   <= cob[j];
    psum <= sx[spm_pkg::PWR_W-1:0];
  end

endmodule

// File: rtl/core/sparse_polynomial_multiplier.sv
// sparse polynomial multiplier: term loader, product generator and accumulator cell chain
// input is accepted only while idle
// multiply: products of all term pairs pass the generator registers, then drain
// through the cell chain; results then leave at one per cycle while m_tready is high,
// in exponent order of first appearance, the chain shifting one cell per accepted result
// empty operand: a single result in the cycle after the request
// sync reset clears term counts, drop flag, cell valid bits and the controller
module sparse_polynomial_multiplier #(
  parameter int MAX_TERMS  = 8,
  parameter int COEFF_BITS = 16,
  parameter int POWER_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // coeff[15:0], power[23:16]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // prod_coeff[37:0], prod_power[46:38], zero pad[47]
  output logic        m_tlast,
  output logic [1:0]  m_tuser    // empty_res[0], dropped[1]
);

  localparam int NCELL = MAX_TERMS * MAX_TERMS;
  localparam int DRN_W = $clog2(NCELL + 1);

  spm_pkg::state_t    state;
  spm_pkg::state_t    state_next;
  logic [DRN_W-1:0]   drain_cnt;
  logic [DRN_W-1:0]   drain_cnt_next;
  spm_pkg::gen_cmd_t  cmd;
  spm_pkg::gen_sts_t  sts;
  spm_pkg::cell_ctl_t ctl;
  spm_pkg::term_t     gen_pkt;
  spm_pkg::term_t     chain [NCELL];
  spm_pkg::term_t     ents  [NCELL+1];
  logic               in_req;
  logic               out_req;

  assign in_req  = s_tvalid && s_tready;
  assign out_req = m_tvalid && m_tready;

  spm_prod_gen #(
    .MAX_TERMS  (MAX_TERMS),
    .COEFF_BITS (COEFF_BITS),
    .POWER_BITS (POWER_BITS)
  ) u_gen (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .coeff (s_tdata[15:0]),
    .power (s_tdata[23:16]),
    .pkt   (gen_pkt),
    .sts   (sts)
  );

  assign ents[NCELL] = '0;

  for (genvar c = 0; c < NCELL; c++) begin : g_cell
    spm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .pkt_in  ((c == 0) ? gen_pkt : chain[(c == 0) ? 0 : c-1]),
      .nbr     (ents[c+1]),
      .pkt_out (chain[c]),
      .ent     (ents[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spm_pkg::ST_IDLE;
      drain_cnt <= '0;
    end else begin
      state     <= state_next;
      drain_cnt <= drain_cnt_next;
    end
  end

  always_comb begin
    state_next     = state;
    drain_cnt_next = drain_cnt;
    cmd            = '0;
    ctl            = '0;
    s_tready       = 1'b0;
    m_tvalid       = 1'b0;
    m_tdata        = '0;
    m_tlast        = 1'b0;
    m_tuser        = '0;
    unique case (state)
      spm_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (in_req) begin
          unique case (s_tuser)
            spm_pkg::KIND_LOAD_A: cmd.load_a = 1'b1;
            spm_pkg::KIND_LOAD_B: cmd.load_b = 1'b1;
            spm_pkg::KIND_MUL: begin
              if (sts.empty) begin
                state_next = spm_pkg::ST_NONE;
              end else begin
                cmd.start  = 1'b1;
                ctl.clr    = 1'b1;
                state_next = spm_pkg::ST_RUN;
              end
            end
            default: ;
          endcase
        end
      end
      spm_pkg::ST_RUN: begin
        if (!sts.busy) begin
          drain_cnt_next = '0;
          state_next     = spm_pkg::ST_DRAIN;
        end
      end
      spm_pkg::ST_DRAIN: begin
        // let the last product walk the whole chain
        drain_cnt_next = drain_cnt + DRN_W'(1);
        if (drain_cnt == DRN_W'(NCELL - 1)) state_next = spm_pkg::ST_EMIT;
      end
      spm_pkg::ST_EMIT: begin
        m_tvalid = 1'b1;
        m_tdata  = {1'b0, ents[0].pwr, ents[0].coef};
        m_tlast  = !ents[1].vld;
        m_tuser  = {sts.ovf, 1'b0};
        if (out_req) begin
          ctl.shift = 1'b1;
          if (m_tlast) begin
            cmd.clr    = 1'b1;
            state_next = spm_pkg::ST_IDLE;
          end
        end
      end
      spm_pkg::ST_NONE: begin
        m_tvalid = 1'b1;
        m_tlast  = 1'b1;
        m_tuser  = {sts.ovf, 1'b1};
        if (out_req) begin
          cmd.clr    = 1'b1;
          state_next = spm_pkg::ST_IDLE;
        end
      end
      default: state_next = spm_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/core/spm_checker.sv
// port-level checks of the sparse polynomial multiplier, bound to the top level
module spm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result withdrawn while stalled");

  // one request at a time: no new request while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast && (m_tdata == '0))
    else $error("empty result not a lone zero term");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
    else $error("results continue after last");

  a_ready_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> s_tready && !m_tvalid)
    else $error("not idle after reset");

endmodule

bind sparse_polynomial_multiplier spm_checker u_spm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
